[hdl/ctp_pkg.sv]
package ctp_pkg;

  // Default parameter values of the top level.
  localparam int CTP_SAMPLE_BITS = 16;
  localparam int CTP_TABLE_DEPTH = 1024;

  // Cycles from an accepted item to its result strobe.
  localparam int CTP_LATENCY = 28;

  // Configuration port geometry.
  localparam int CTP_ADDR_BITS = 5;
  localparam int CTP_DATA_BITS = 64;
  localparam int CTP_REG_BITS  = 48;

  // Reset value of the deviation registers: 1.0 in Q4.12 in every lane.
  localparam logic [CTP_REG_BITS-1:0] CTP_ONE_LANES = 48'h1000_1000_1000;
  localparam logic [15:0] CTP_GAIN_ONE = 16'h1000;

  // Restoring division steps for the 29-bit gain dividend.
  localparam int CTP_DIV_STEPS = 29;

  typedef enum logic [1:0] {
    REG_SRC_AVG  = 2'd0,
    REG_SRC_DEV  = 2'd1,
    REG_TGT_MEAN = 2'd2,
    REG_TGT_DEV  = 2'd3
  } ctp_reg_e;

  // Per-lane transfer settings handed to the pixel path (lane 0 = l).
  typedef struct packed {
    logic [2:0][15:0] src_avg;
    logic [2:0][15:0] tgt_mean;
    logic [2:0][15:0] gain;
  } xfer_cfg_t;

  // RGB to LMS coefficients, Q0.14.
  localparam logic [13:0] LMS_COEF [3][3] = '{
    '{14'd6244, 14'd9475,  14'd659},
    '{14'd3223, 14'd11869, 14'd1281},
    '{14'd395,  14'd2110,  14'd13835}
  };

  // Mixing coefficients between LMS roots and l-alpha-beta, Q.14.
  localparam int MIX_L  = 9459;
  localparam int MIX_A  = 6689;
  localparam int MIX_A2 = 13378;
  localparam int MIX_B  = 11585;

  // Inverse LMS to RGB coefficients applied to Q.24 powers.
  localparam logic signed [17:0] OUT_COEF [3][3] = '{
    '{18'sd73214,  -18'sd58796, 18'sd1960},
    '{-18'sd19984, 18'sd39043,  -18'sd2664},
    '{18'sd958,    -18'sd4276,  18'sd19753}
  };

  // Shift right by n with rounding half away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                     input int unsigned n);
    logic [63:0] h;
    logic [63:0] m;
    h = 64'd1 << (n - 1);
    if (x >= 0) begin
      m = (unsigned'(x) + h) >> n;
      return signed'(m);
    end else begin
      m = (unsigned'(-x) + h) >> n;
      return -signed'(m);
    end
  endfunction

endpackage

[hdl/ctp_gain_div.sv]
module ctp_gain_div
  import ctp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] src_dev_i,
  input  logic [15:0] tgt_dev_i,
  output logic        busy_o,
  output logic [15:0] gain_o
);

  localparam int CntBits = $clog2(CTP_DIV_STEPS);

  logic               run_q;
  logic [CntBits-1:0] cnt_q;
  logic [15:0]        sd_q;
  logic [15:0]        rem_q;
  logic [28:0]        quo_q;
  logic [15:0]        gain_q;

  logic [16:0] trial;
  logic        fits;
  logic [28:0] quo_next;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial    = {rem_q, quo_q[28]};
    fits     = trial >= {1'b0, sd_q};
    quo_next = {quo_q[27:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      gain_q <= CTP_GAIN_ONE;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(CTP_DIV_STEPS - 1)) begin
        run_q <= 1'b0;
        if (sd_q == '0) begin
          gain_q <= '0;
        end else if (quo_next[28:16] != '0) begin
          gain_q <= '1;
        end else begin
          gain_q <= quo_next[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sd_q  <= src_dev_i;
      rem_q <= '0;
      quo_q <= {1'b0, tgt_dev_i, 12'b0} + {14'b0, src_dev_i[15:1]};
    end else if (run_q) begin
      rem_q <= fits ? 16'(trial - {1'b0, sd_q}) : trial[15:0];
      quo_q <= quo_next;
    end
  end

  assign busy_o = run_q;
  assign gain_o = gain_q;

endmodule

[hdl/ctp_cfg_regs.sv]
module ctp_cfg_regs
  import ctp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CTP_ADDR_BITS-1:0] paddr,
  input  logic [CTP_DATA_BITS-1:0] pwdata,
  output logic [CTP_DATA_BITS-1:0] prdata,
  output logic                     busy_o,
  output xfer_cfg_t                cfg_o
);

  logic [CTP_REG_BITS-1:0] src_avg_q, src_dev_q, tgt_mean_q, tgt_dev_q;
  logic                    pend_q;
  logic                    wr;
  ctp_reg_e                idx;
  logic [2:0]              div_busy;
  logic [2:0][15:0]        gain;

  assign wr  = psel && penable && pwrite;
  assign idx = ctp_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_avg_q  <= '0;
      src_dev_q  <= CTP_ONE_LANES;
      tgt_mean_q <= '0;
      tgt_dev_q  <= CTP_ONE_LANES;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= wr;
      if (wr) begin
        unique case (idx)
          REG_SRC_AVG:  src_avg_q  <= pwdata[CTP_REG_BITS-1:0];
          REG_SRC_DEV:  src_dev_q  <= pwdata[CTP_REG_BITS-1:0];
          REG_TGT_MEAN: tgt_mean_q <= pwdata[CTP_REG_BITS-1:0];
          REG_TGT_DEV:  tgt_dev_q  <= pwdata[CTP_REG_BITS-1:0];
          default:      src_avg_q  <= src_avg_q;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_SRC_AVG:  prdata = {16'b0, src_avg_q};
      REG_SRC_DEV:  prdata = {16'b0, src_dev_q};
      REG_TGT_MEAN: prdata = {16'b0, tgt_mean_q};
      REG_TGT_DEV:  prdata = {16'b0, tgt_dev_q};
      default:      prdata = '0;
    endcase
  end

  // The gains are recomputed from the updated registers, starting in the cycle after a write.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    ctp_gain_div u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (pend_q),
      .src_dev_i (src_dev_q[16*k +: 16]),
      .tgt_dev_i (tgt_dev_q[16*k +: 16]),
      .busy_o    (div_busy[k]),
      .gain_o    (gain[k])
    );
  end

  assign busy_o         = pend_q || (div_busy != '0);
  assign cfg_o.src_avg  = src_avg_q;
  assign cfg_o.tgt_mean = tgt_mean_q;
  assign cfg_o.gain     = gain;

endmodule

[hdl/ctp_root_rom.sv]
module ctp_root_rom
  import ctp_pkg::*;
#(
  parameter int TableDepth = CTP_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic [$clog2(TableDepth)-1:0] addr_i,
  output logic [25:0]                   data_o
);

  // Each word holds the neighbor pair {entry[i+1], entry[i]} of the root table.
  typedef logic [25:0] rom_t [TableDepth];

  function automatic longint unsigned tenth_power(input longint unsigned mag12);
    longint unsigned q;
    longint unsigned p;
    q = mag12 << 12;
    p = q;
    for (int i = 0; i < 9; i++) begin
      p = (p * q + (64'd1 << 23)) >> 24;
    end
    return p;
  endfunction

  function automatic rom_t build_rom();
    rom_t            tbl;
    logic [12:0]     root [TableDepth];
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned lim;
    for (int i = 0; i < TableDepth; i++) begin
      lo  = 0;
      hi  = 4096;
      lim = longint'(i) << 24;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (tenth_power(mid) * longint'(TableDepth - 1) <= lim) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      root[i] = 13'(lo);
    end
    for (int i = 0; i < TableDepth - 1; i++) begin
      tbl[i] = {root[i+1], root[i]};
    end
    tbl[TableDepth-1] = {root[TableDepth-1], root[TableDepth-1]};
    return tbl;
  endfunction

  localparam rom_t RomTable = build_rom();

  logic [25:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= RomTable[addr_i];
  end

  assign data_o = data_q;

endmodule

[hdl/ctp_pixel_path.sv]
module ctp_pixel_path
  import ctp_pkg::*;
#(
  parameter int SampleBits = CTP_SAMPLE_BITS,
  parameter int TableDepth = CTP_TABLE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [SampleBits-1:0] red_i,
  input  logic [SampleBits-1:0] green_i,
  input  logic [SampleBits-1:0] blue_i,
  input  logic [SampleBits-1:0] alpha_i,
  input  xfer_cfg_t             cfg_i,
  output logic                  out_valid_o,
  output logic [SampleBits-1:0] red_o,
  output logic [SampleBits-1:0] green_o,
  output logic [SampleBits-1:0] blue_o,
  output logic [SampleBits-1:0] alpha_o
);

  localparam int IdxBits  = $clog2(TableDepth);
  localparam int TBits    = 16 + IdxBits;
  localparam int AccW     = SampleBits + 16;
  localparam int PowSteps = 9;
  localparam logic [AccW-1:0] LmsRnd = AccW'(1) << (SampleBits - 3);
  localparam logic [SampleBits-1:0] SampleMax = '1;

  function automatic logic [15:0] lms_row(input logic [SampleBits-1:0] r,
                                          input logic [SampleBits-1:0] g,
                                          input logic [SampleBits-1:0] b,
                                          input int row);
    logic [AccW-1:0] acc;
    acc = AccW'(LMS_COEF[row][0]) * AccW'(r) + AccW'(LMS_COEF[row][1]) * AccW'(g)
        + AccW'(LMS_COEF[row][2]) * AccW'(b) + LmsRnd;
    return acc[SampleBits+13 -: 16];
  endfunction

  function automatic logic [SampleBits-1:0] to_sample(input logic signed [63:0] acc);
    logic [63:0] v;
    if (acc <= 0) begin
      return '0;
    end
    v = (unsigned'(acc) + (64'd1 << (37 - SampleBits))) >> (38 - SampleBits);
    if (v > 64'(SampleMax)) begin
      return SampleMax;
    end
    return v[SampleBits-1:0];
  endfunction

  logic                  vld_q   [CTP_LATENCY];
  logic [SampleBits-1:0] alpha_q [CTP_LATENCY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CTP_LATENCY; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < CTP_LATENCY; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q[0] <= alpha_i;
    for (int i = 1; i < CTP_LATENCY; i++) begin
      alpha_q[i] <= alpha_q[i-1];
    end
  end

  // Stage 1: RGB to LMS.
  logic [15:0] lms_q [3];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      lms_q[c] <= lms_row(red_i, green_i, blue_i, c);
    end
  end

  // Stage 2: table position and interpolation fraction.
  logic [IdxBits-1:0] idx_q   [3];
  logic [15:0]        frac2_q [3];

  always_ff @(posedge clk_i) begin
    logic [TBits-1:0]   t;
    logic [IdxBits-1:0] idx;
    for (int c = 0; c < 3; c++) begin
      t   = TBits'(lms_q[c]) * TBits'(TableDepth - 1);
      idx = t[TBits-1:16];
      if (idx > IdxBits'(TableDepth - 2)) begin
        idx = IdxBits'(TableDepth - 2);
      end
      idx_q[c]   <= idx;
      frac2_q[c] <= t[15:0];
    end
  end

  // Stage 3: table read.
  logic [25:0] pair [3];
  logic [15:0] frac3_q [3];

  for (genvar c = 0; c < 3; c++) begin : g_rom
    ctp_root_rom #(
      .TableDepth (TableDepth)
    ) u_rom (
      .clk_i  (clk_i),
      .addr_i (idx_q[c]),
      .data_o (pair[c])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      frac3_q[c] <= frac2_q[c];
    end
  end

  // Stage 4: linear interpolation of the tenth root.
  logic [12:0] root_q [3];

  always_ff @(posedge clk_i) begin
    logic [12:0] a;
    logic [12:0] diff;
    logic [28:0] step;
    for (int c = 0; c < 3; c++) begin
      a    = pair[c][12:0];
      diff = pair[c][25:13] - a;
      step = (29'(diff) * 29'(frac3_q[c]) + 29'd32768) >> 16;
      root_q[c] <= a + step[12:0];
    end
  end

  // Stage 5: roots to l-alpha-beta.
  logic signed [15:0] lab_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [31:0] r0, r1, r2;
    r0 = signed'({19'b0, root_q[0]});
    r1 = signed'({19'b0, root_q[1]});
    r2 = signed'({19'b0, root_q[2]});
    lab_q[0] <= 16'(round_shift(64'(MIX_L * (r0 + r1 + r2)), 14));
    lab_q[1] <= 16'(round_shift(64'(MIX_A * (r0 + r1) - MIX_A2 * r2), 14));
    lab_q[2] <= 16'(round_shift(64'(MIX_B * (r0 - r1)), 14));
  end

  // Stage 6: remove the source mean and scale by the lane gain.
  logic signed [21:0] tr_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [16:0] d;
    logic signed [63:0] pr;
    for (int c = 0; c < 3; c++) begin
      d  = 17'(lab_q[c]) - 17'(signed'(cfg_i.src_avg[c]));
      pr = 64'(d) * 64'(signed'({1'b0, cfg_i.gain[c]}));
      tr_q[c] <= 22'(round_shift(pr, 12));
    end
  end

  // Stage 7: add the target mean and saturate to Q3.12.
  logic signed [15:0] labt_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [22:0] s;
    for (int c = 0; c < 3; c++) begin
      s = 23'(tr_q[c]) + 23'(signed'(cfg_i.tgt_mean[c]));
      if (s > 23'sd32767) begin
        labt_q[c] <= 16'sh7fff;
      end else if (s < -23'sd32768) begin
        labt_q[c] <= 16'sh8000;
      end else begin
        labt_q[c] <= s[15:0];
      end
    end
  end

  // Stage 8: back to LMS roots, magnitude limited to 2.0, scaled to Q.24.
  logic [34:0] p_q  [PowSteps+1][3];
  logic [25:0] q_q  [PowSteps][3];

  always_ff @(posedge clk_i) begin
    logic signed [63:0] x0, x1, x2;
    logic signed [63:0] v [3];
    logic [63:0]        am;
    logic [13:0]        mag;
    x0 = 64'(labt_q[0]);
    x1 = 64'(labt_q[1]);
    x2 = 64'(labt_q[2]);
    v[0] = round_shift(MIX_L * x0 + MIX_A * x1 + MIX_B * x2, 14);
    v[1] = round_shift(MIX_L * x0 + MIX_A * x1 - MIX_B * x2, 14);
    v[2] = round_shift(MIX_L * x0 - MIX_A2 * x1, 14);
    for (int c = 0; c < 3; c++) begin
      am  = (v[c] < 0) ? unsigned'(-v[c]) : unsigned'(v[c]);
      mag = (am > 64'd8192) ? 14'd8192 : am[13:0];
      q_q[0][c] <= {mag, 12'b0};
      p_q[0][c] <= {9'b0, mag, 12'b0};
    end
  end

  // Stages 9 to 26: nine rounded multiplications, each split into a
  // partial-product stage and a recombining stage.
  logic [36:0] ph_q [PowSteps][3];
  logic [49:0] pl_q [PowSteps][3];

  for (genvar s = 0; s < PowSteps; s++) begin : g_pow
    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 3; c++) begin
        ph_q[s][c] <= 37'(p_q[s][c][34:24]) * 37'(q_q[s][c]);
        pl_q[s][c] <= 50'(p_q[s][c][23:0]) * 50'(q_q[s][c]);
      end
    end

    always_ff @(posedge clk_i) begin
      logic [49:0] lo;
      for (int c = 0; c < 3; c++) begin
        lo = (pl_q[s][c] + 50'(1 << 23)) >> 24;
        p_q[s+1][c] <= 35'(ph_q[s][c] + 37'(lo));
      end
    end

    if (s < PowSteps - 1) begin : g_q
      logic [25:0] qm_q [3];
      always_ff @(posedge clk_i) begin
        for (int c = 0; c < 3; c++) begin
          qm_q[c]        <= q_q[s][c];
          q_q[s+1][c]    <= qm_q[c];
        end
      end
    end
  end

  // Stage 27: inverse LMS matrix, low and high halves of the powers apart.
  logic signed [44:0] lo_sum_q [3];
  logic signed [31:0] hi_sum_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    for (int r = 0; r < 3; r++) begin
      lo = '0;
      hi = '0;
      for (int c = 0; c < 3; c++) begin
        lo = lo + OUT_COEF[r][c] * signed'({40'b0, p_q[PowSteps][c][23:0]});
        hi = hi + OUT_COEF[r][c] * signed'({53'b0, p_q[PowSteps][c][34:24]});
      end
      lo_sum_q[r] <= 45'(lo);
      hi_sum_q[r] <= 32'(hi);
    end
  end

  // Stage 28: recombine, round and saturate to the sample range.
  logic [SampleBits-1:0] rgb_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [63:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = (64'(hi_sum_q[r]) <<< 24) + 64'(lo_sum_q[r]);
      rgb_q[r] <= to_sample(acc);
    end
  end

  assign out_valid_o = vld_q[CTP_LATENCY-1];
  assign red_o       = rgb_q[0];
  assign green_o     = rgb_q[1];
  assign blue_o      = rgb_q[2];
  assign alpha_o     = alpha_q[CTP_LATENCY-1];

endmodule

[hdl/color_transfer_pixel_pipeline_unit.sv]
// Color transfer pixel pipeline: statistics matching in l-alpha-beta space.
//
// Pixels enter on the command channel. An item is accepted at a rising edge
// where start is high and busy is low; red, green, blue and alpha samples are
// taken from their ports at that edge. While busy is low the block accepts
// one item per clock. Every accepted item produces exactly one result: the
// result ports hold it for one cycle, marked by result_valid_o, and it is
// taken at the edge that ends that cycle. The receiver cannot stall the
// block, and nothing in the datapath ever waits, so the pipeline runs at one
// item per clock.
//
// The four 48-bit statistics registers sit on the APB port at byte addresses
// 0, 8, 16 and 24. After any write the three lane gains are recomputed by
// bit-serial dividers; busy rises at the write edge and stays high until the
// dividers finish, and no item is accepted meanwhile. Registers should be
// written only while the pipeline is empty.
//
// Reset clears the pipeline valid bits, loads zero means, unit deviations and
// unit gains. The root table is a constant ROM and needs no loading.
module color_transfer_pixel_pipeline_unit
  import ctp_pkg::*;
#(
  parameter int SAMPLE_BITS       = CTP_SAMPLE_BITS,
  parameter int POWER_TABLE_DEPTH = CTP_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [SAMPLE_BITS-1:0]   red_in_i,
  input  logic [SAMPLE_BITS-1:0]   green_in_i,
  input  logic [SAMPLE_BITS-1:0]   blue_in_i,
  input  logic [SAMPLE_BITS-1:0]   alpha_in_i,
  output logic                     result_valid_o,
  output logic [SAMPLE_BITS-1:0]   red_out_o,
  output logic [SAMPLE_BITS-1:0]   green_out_o,
  output logic [SAMPLE_BITS-1:0]   blue_out_o,
  output logic [SAMPLE_BITS-1:0]   alpha_out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CTP_ADDR_BITS-1:0] paddr,
  input  logic [CTP_DATA_BITS-1:0] pwdata,
  output logic [CTP_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  xfer_cfg_t xfer_cfg;
  logic      accept;

  // The only stall source is the gain recomputation after a register write.
  assign accept = start && !busy;
  assign pready = 1'b1;

  ctp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .busy_o  (busy),
    .cfg_o   (xfer_cfg)
  );

  // The pixel path is a fixed 28-stage pipeline with valid bits in step.
  ctp_pixel_path #(
    .SampleBits (SAMPLE_BITS),
    .TableDepth (POWER_TABLE_DEPTH)
  ) u_path (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .alpha_i     (alpha_in_i),
    .cfg_i       (xfer_cfg),
    .out_valid_o (result_valid_o),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .alpha_o     (alpha_out_o)
  );

endmodule

[hdl/ctp_checker.sv]
module ctp_checker
  import ctp_pkg::*;
#(
  parameter int SampleBits = CTP_SAMPLE_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic [SampleBits-1:0] alpha_in_i,
  input logic [SampleBits-1:0] alpha_out_o,
  input logic                  result_valid_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite
);

  // Every accepted item yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##CTP_LATENCY result_valid_o)
    else $error("accepted item produced no result after the pipeline latency");

  // No result appears without an item accepted at the matching edge.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, CTP_LATENCY))
    else $error("result strobe without a matching accepted item");

  // Alpha travels with its pixel.
  a_alpha_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (alpha_out_o == $past(alpha_in_i, CTP_LATENCY)))
    else $error("alpha sample does not match its item");

  // A register write raises busy, which holds off items while the gains are recomputed.
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy)
    else $error("no busy after a register write");

endmodule

bind color_transfer_pixel_pipeline_unit ctp_checker #(
  .SampleBits (SAMPLE_BITS)
) u_ctp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .alpha_in_i     (alpha_in_i),
  .alpha_out_o    (alpha_out_o),
  .result_valid_o (result_valid_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite)
);
